// File: rtl/ltt_pkg.sv
// Shared types, codes and sizes for the log transaction tracker.
package ltt_pkg;

  localparam int LOG_DEPTH = 32;
  // Usable entries: the table depth, never more than 32.
  localparam int LIM_MAX   = (LOG_DEPTH < 32) ? LOG_DEPTH : 32;
  localparam int CNT_W     = $clog2(LIM_MAX + 1);
  localparam int CFG_W     = 6;
  localparam int OPEN_W    = 6;
  localparam int NEED_W    = 13;
  localparam int BLK_W     = 16;
  localparam int ADDR_W    = 3;
  localparam int DATA_W    = 32;

  localparam logic [1:0] K_BEGIN = 2'd0;
  localparam logic [1:0] K_END   = 2'd1;
  localparam logic [1:0] K_WRITE = 2'd2;
  localparam logic [1:0] K_DONE  = 2'd3;

  localparam logic [3:0] ST_GRANTED      = 4'd0;
  localparam logic [3:0] ST_WAIT         = 4'd1;
  localparam logic [3:0] ST_END_OK       = 4'd2;
  localparam logic [3:0] ST_COMMIT_BLOCK = 4'd3;
  localparam logic [3:0] ST_COMMIT_EMPTY = 4'd4;
  localparam logic [3:0] ST_ABSORBED     = 4'd5;
  localparam logic [3:0] ST_APPENDED     = 4'd6;
  localparam logic [3:0] ST_DONE         = 4'd7;
  localparam logic [3:0] ST_ERROR        = 4'd8;

  localparam logic REG_CAP = 1'b0;
  localparam logic REG_RSV = 1'b1;

  localparam logic [OPEN_W-1:0] OPEN_MAX = 6'd63;

  // Search probe travelling down the cell row.
  typedef struct packed {
    logic             valid;
    logic             hit;
    logic [BLK_W-1:0] key;
  } probe_t;

  // Per-cell control from the sequencer.
  typedef struct packed {
    logic load;
    logic shift;
    logic active;
  } cell_ctl_t;

endpackage

// File: rtl/ltt_cell.sv
// One table cell: holds a logged block, compares a passing probe, shifts on commit.
module ltt_cell import ltt_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  cell_ctl_t        ctl,
  input  logic [BLK_W-1:0] load_data,
  input  logic [BLK_W-1:0] shift_in,
  input  probe_t           probe_in,
  output probe_t           probe_out,
  output logic [BLK_W-1:0] entry
);

  always_ff @(posedge clk) begin
    if (rst) begin
      probe_out.valid <= 1'b0;
    end else begin
      probe_out.valid <= probe_in.valid;
    end
    probe_out.key <= probe_in.key;
    probe_out.hit <= probe_in.hit | (ctl.active & (entry == probe_in.key));
  end

  // table payload, no reset
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      entry <= load_data;
    end else if (ctl.shift) begin
      entry <= shift_in;
    end
  end

endmodule

// File: rtl/log_transaction_tracker.sv
// Top level of the log transaction tracker: sequencer, cell row and register port.
//
// Write-ahead log bookkeeping. Each item is a begin, end, write or commit-done
// request. Begin, end and commit-done items are answered at once with a single
// registered result, save an end that starts a non-empty commit. A write sends
// a probe down a row of LOG_DEPTH cells, one cell per cycle, and its result
// (absorbed or appended) is ready once the probe leaves the row; a write that
// errors up front is answered at once. The end that closes the last open call
// starts a commit, which streams out the logged blocks, up to the effective
// capacity, in table order, one result per cycle while the output is not
// stalled, by shifting the row towards cell 0; the last result carries last.
// A new item is taken only once the previous one has produced all of its
// results, but a result may still sit in the output register meanwhile.
// Registers: log_capacity at address 0, reservation_per_call at address 4,
// low six bits kept. No clearing pass is needed after reset.
module log_transaction_tracker import ltt_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  // input items
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        kind,
  input  logic [BLK_W-1:0]  block_number,
  // result items
  output logic              out_valid,
  input  logic              out_stall,
  output logic [3:0]        status,
  output logic [BLK_W-1:0]  logged_block,
  output logic              last,
  // register port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SEARCH = 2'd1;
  localparam logic [1:0] S_COMMIT = 2'd2;

  logic [1:0]        state;
  logic [CFG_W-1:0]  log_capacity;
  logic [CFG_W-1:0]  reservation_per_call;
  logic [CNT_W-1:0]  entry_count;
  logic [OPEN_W-1:0] open_calls;
  logic              commit_running;
  logic [CNT_W-1:0]  remaining;

  // result slot ahead of the output register
  logic              res_valid;
  logic [3:0]        res_status;
  logic [BLK_W-1:0]  res_block;
  logic              res_last;

  probe_t            probe_src;
  probe_t            probe_chain [LOG_DEPTH+1];
  cell_ctl_t         cell_ctl    [LOG_DEPTH];
  logic [BLK_W-1:0]  entries     [LOG_DEPTH+1];

  logic              accept;
  logic              res_move;
  logic              cfg_write;
  logic              append;
  logic              shift;
  logic [CNT_W-1:0]  lim;
  logic [CNT_W-1:0]  n_used;
  logic [OPEN_W:0]   open_plus;
  logic [NEED_W-1:0] need;
  probe_t            probe_end;

  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite & pready;
  assign in_stall  = (state != S_IDLE) | res_valid;
  assign accept    = in_valid & ~in_stall;
  assign res_move  = res_valid & (~out_valid | ~out_stall);
  assign probe_end = probe_chain[LOG_DEPTH];

  always_comb begin
    case (paddr[2])
      REG_CAP: prdata = {{(DATA_W-CFG_W){1'b0}}, log_capacity};
      REG_RSV: prdata = {{(DATA_W-CFG_W){1'b0}}, reservation_per_call};
      default: prdata = '0;
    endcase
  end

  // effective capacity and admission sum
  always_comb begin
    if (log_capacity > CFG_W'(LIM_MAX)) begin
      lim = CNT_W'(LIM_MAX);
    end else begin
      lim = CNT_W'(log_capacity);
    end
    n_used    = (entry_count > lim) ? lim : entry_count;
    open_plus = {1'b0, open_calls} + (OPEN_W+1)'(1);
    need      = NEED_W'(entry_count) + NEED_W'(open_plus * reservation_per_call);
  end

  assign append = (state == S_SEARCH) & probe_end.valid & ~probe_end.hit;
  assign shift  = (state == S_COMMIT) & (~res_valid | res_move);

  // the cell row
  assign probe_chain[0]     = probe_src;
  assign entries[LOG_DEPTH] = '0;

  for (genvar i = 0; i < LOG_DEPTH; i++) begin : g_cell
    if (i < LIM_MAX) begin : g_used
      assign cell_ctl[i].load   = append & (entry_count == CNT_W'(i));
      assign cell_ctl[i].active = CNT_W'(i) < entry_count;
    end else begin : g_spare
      assign cell_ctl[i].load   = 1'b0;
      assign cell_ctl[i].active = 1'b0;
    end
    assign cell_ctl[i].shift = shift;

    ltt_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctl       (cell_ctl[i]),
      .load_data (probe_end.key),
      .shift_in  (entries[i+1]),
      .probe_in  (probe_chain[i]),
      .probe_out (probe_chain[i+1]),
      .entry     (entries[i])
    );
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_move) begin
      out_valid <= 1'b1;
    end else if (~out_stall) begin
      out_valid <= 1'b0;
    end
    if (res_move) begin
      status       <= res_status;
      logged_block <= res_block;
      last         <= res_last;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state                <= S_IDLE;
      log_capacity         <= CFG_W'(32);
      reservation_per_call <= CFG_W'(10);
      entry_count          <= '0;
      open_calls           <= '0;
      commit_running       <= 1'b0;
      res_valid            <= 1'b0;
      probe_src.valid      <= 1'b0;
      remaining            <= '0;
    end else begin
      probe_src.valid <= 1'b0;
      if (res_move) begin
        res_valid <= 1'b0;
      end

      if (cfg_write) begin
        case (paddr[2])
          REG_CAP: log_capacity         <= pwdata[CFG_W-1:0];
          REG_RSV: reservation_per_call <= pwdata[CFG_W-1:0];
          default: ;
        endcase
      end

      case (state)
        S_IDLE: begin
          if (accept) begin
            res_valid <= 1'b1;
            res_block <= '0;
            res_last  <= 1'b1;
            case (kind)
              K_BEGIN: begin
                if (commit_running || open_calls >= OPEN_MAX ||
                    need > NEED_W'(lim)) begin
                  res_status <= ST_WAIT;
                end else begin
                  open_calls <= open_calls + OPEN_W'(1);
                  res_status <= ST_GRANTED;
                end
              end
              K_END: begin
                if (open_calls == '0 || commit_running) begin
                  res_status <= ST_ERROR;
                end else if (open_calls != OPEN_W'(1)) begin
                  open_calls <= open_calls - OPEN_W'(1);
                  res_status <= ST_END_OK;
                end else begin
                  open_calls     <= '0;
                  commit_running <= 1'b1;
                  if (n_used == '0) begin
                    res_status <= ST_COMMIT_EMPTY;
                  end else begin
                    // commit stream fills the result slot from the row
                    res_valid <= 1'b0;
                    remaining <= n_used;
                    state     <= S_COMMIT;
                  end
                end
              end
              K_WRITE: begin
                if (open_calls == '0 || entry_count >= lim) begin
                  res_status <= ST_ERROR;
                end else begin
                  res_valid       <= 1'b0;
                  probe_src.valid <= 1'b1;
                  probe_src.hit   <= 1'b0;
                  probe_src.key   <= block_number;
                  state           <= S_SEARCH;
                end
              end
              K_DONE: begin
                if (!commit_running) begin
                  res_status <= ST_ERROR;
                end else begin
                  entry_count    <= '0;
                  commit_running <= 1'b0;
                  res_status     <= ST_DONE;
                end
              end
              default: ;
            endcase
          end
        end

        S_SEARCH: begin
          // slot is empty here: it was empty when the write was taken
          if (probe_end.valid) begin
            res_valid <= 1'b1;
            res_block <= '0;
            res_last  <= 1'b1;
            if (probe_end.hit) begin
              res_status <= ST_ABSORBED;
            end else begin
              entry_count <= entry_count + CNT_W'(1);
              res_status  <= ST_APPENDED;
            end
            state <= S_IDLE;
          end
        end

        S_COMMIT: begin
          if (shift) begin
            res_valid  <= 1'b1;
            res_status <= ST_COMMIT_BLOCK;
            res_block  <= entries[0];
            res_last   <= (remaining == CNT_W'(1));
            remaining  <= remaining - CNT_W'(1);
            if (remaining == CNT_W'(1)) begin
              state <= S_IDLE;
            end
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
